### hw/rtl/collinearity_point_projection_defines.svh
// Assertion macros shared by the collinearity point projection RTL.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef COLLINEARITY_POINT_PROJECTION_DEFINES_SVH
`define COLLINEARITY_POINT_PROJECTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/cpp_pkg.sv
// Shared types, constants and width helpers for the collinearity point projection.
// Depends on nothing; used by every module of the block.
package cpp_pkg;

	localparam int CFG_DATA_BITS = 54;
	localparam int CFG_IDX_BITS  = 3;
	localparam int ROT_BITS      = 54;
	localparam int CAM_BITS      = 32;
	localparam int FOCAL_BITS    = 20;
	localparam int IMG_BITS      = 32;
	localparam int QUO_BITS      = 32;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ROT_COL0  = 3'd0,
		REG_ROT_COL1  = 3'd1,
		REG_ROT_COL2  = 3'd2,
		REG_CAM_X     = 3'd3,
		REG_CAM_Y     = 3'd4,
		REG_CAM_Z     = 3'd5,
		REG_FOCAL_LEN = 3'd6
	} cpp_reg_t;

	localparam logic [ROT_BITS-1:0] ROT_COL0_RST = 54'd65536;
	localparam logic [ROT_BITS-1:0] ROT_COL1_RST = 54'd17179869184;
	localparam logic [ROT_BITS-1:0] ROT_COL2_RST = 54'd4503599627370496;

	localparam logic [IMG_BITS-1:0] IMG_MAX_POS = 32'h7FFF_FFFF;
	localparam logic [IMG_BITS-1:0] IMG_MAX_NEG = 32'h8000_0000;

	typedef struct packed {
		logic valid;
		logic zero;
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
	} cpp_ctl_t;

	// Width of the rotated coordinates, which wrap modulo 2^64 at most.
	function automatic int cpp_t_bits(input int coord_bits, input int coef_frac_bits);
		int dw;
		int sw;
		dw = ((coord_bits > CAM_BITS) ? coord_bits : CAM_BITS) + 1;
		sw = dw + coef_frac_bits + 2 + 2;
		return (sw > 64) ? 64 : sw;
	endfunction

endpackage

### hw/rtl/cpp_rotate.sv
// Translation and rotation stages: subtract the camera centre, nine products, column sums.
// Depends on cpp_pkg.
module cpp_rotate #(
	parameter int COORD_BITS     = 32,
	parameter int COEF_FRAC_BITS = 16,
	parameter int T_BITS         = 53
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid,
	input  logic signed [COORD_BITS-1:0]        pt_x,
	input  logic signed [COORD_BITS-1:0]        pt_y,
	input  logic signed [COORD_BITS-1:0]        pt_z,
	input  logic [cpp_pkg::ROT_BITS-1:0]        rot_col0,
	input  logic [cpp_pkg::ROT_BITS-1:0]        rot_col1,
	input  logic [cpp_pkg::ROT_BITS-1:0]        rot_col2,
	input  logic signed [cpp_pkg::CAM_BITS-1:0] cam_x,
	input  logic signed [cpp_pkg::CAM_BITS-1:0] cam_y,
	input  logic signed [cpp_pkg::CAM_BITS-1:0] cam_z,
	output logic                                t_valid,
	output logic [T_BITS-1:0]                   t_x,
	output logic [T_BITS-1:0]                   t_y,
	output logic [T_BITS-1:0]                   t_z
);
	import cpp_pkg::*;

	localparam int COEF_BITS = COEF_FRAC_BITS + 2;
	localparam int DW = ((COORD_BITS > CAM_BITS) ? COORD_BITS : CAM_BITS) + 1;
	localparam int PW = DW + COEF_BITS;
	localparam int SW = PW + 2;
	localparam int FW = 3 * COEF_BITS;

	logic [FW+ROT_BITS-1:0]       col_wide [3];
	logic signed [COEF_BITS-1:0]  coef [3][3];
	logic signed [DW-1:0]         d_s1 [3];
	logic                         valid_s1;
	logic signed [PW-1:0]         prod_s2 [3][3];
	logic                         valid_s2;
	logic signed [SW-1:0]         sum [3];
	logic [T_BITS-1:0]            t_s3 [3];
	logic                         valid_s3;

	always_comb begin
		col_wide[0] = {{FW{1'b0}}, rot_col0};
		col_wide[1] = {{FW{1'b0}}, rot_col1};
		col_wide[2] = {{FW{1'b0}}, rot_col2};
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 3; k++) begin
				coef[c][k] = signed'(col_wide[c][k*COEF_BITS +: COEF_BITS]);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = SW'(prod_s2[c][0]) + SW'(prod_s2[c][1]) + SW'(prod_s2[c][2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= DW'(pt_x) - DW'(cam_x);
			d_s1[1] <= DW'(pt_y) - DW'(cam_y);
			d_s1[2] <= DW'(pt_z) - DW'(cam_z);
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[c][k] <= PW'(coef[c][k]) * PW'(d_s1[k]);
				end
				t_s3[c] <= sum[c][T_BITS-1:0];
			end
		end
	end

	assign t_valid = valid_s3;
	assign t_x     = t_s3[0];
	assign t_y     = t_s3[1];
	assign t_z     = t_s3[2];

endmodule

### hw/rtl/cpp_scale.sv
// Magnitude, focal-length product and divider set-up stages.
// Depends on cpp_pkg.
module cpp_scale #(
	parameter int T_BITS = 53
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 t_valid,
	input  logic [T_BITS-1:0]                    t_x,
	input  logic [T_BITS-1:0]                    t_y,
	input  logic [T_BITS-1:0]                    t_z,
	input  logic [cpp_pkg::FOCAL_BITS-1:0]       focal,
	output cpp_pkg::cpp_ctl_t                    ctl,
	output logic [T_BITS-1:0]                    den,
	output logic [T_BITS-1:0]                    rem_x,
	output logic [T_BITS-1:0]                    rem_y,
	output logic [cpp_pkg::QUO_BITS-1:0]         nq_x,
	output logic [cpp_pkg::QUO_BITS-1:0]         nq_y
);
	import cpp_pkg::*;

	localparam int H      = (T_BITS + 1) / 2;
	localparam int HH     = T_BITS - H;
	localparam int N_BITS = FOCAL_BITS + T_BITS;

	cpp_ctl_t                  ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [T_BITS-1:0]         mag_x_s4, mag_y_s4, den_s4;
	logic [FOCAL_BITS+H-1:0]   plo_x_s5, plo_y_s5;
	logic [FOCAL_BITS+HH-1:0]  phi_x_s5, phi_y_s5;
	logic [T_BITS-1:0]         den_s5, den_s6, den_s7;
	logic [N_BITS-1:0]         num_x_s6, num_y_s6;
	logic [T_BITS-1:0]         rem_x_s7, rem_y_s7;
	logic [QUO_BITS-1:0]       nq_x_s7, nq_y_s7;
	logic [T_BITS-1:0]         hi_x, hi_y;
	cpp_ctl_t                  ctl_n4, ctl_n7;

	assign hi_x = T_BITS'(num_x_s6[N_BITS-1:QUO_BITS]);
	assign hi_y = T_BITS'(num_y_s6[N_BITS-1:QUO_BITS]);

	always_comb begin
		ctl_n4       = '0;
		ctl_n4.valid = t_valid;
		ctl_n4.zero  = (t_z == '0);
		ctl_n4.neg_x = (t_x[T_BITS-1] == t_z[T_BITS-1]);
		ctl_n4.neg_y = (t_y[T_BITS-1] == t_z[T_BITS-1]);
		ctl_n7       = ctl_s6;
		ctl_n7.ovf_x = (hi_x >= den_s6);
		ctl_n7.ovf_y = (hi_y >= den_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_n4;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_n7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_x_s4 <= t_x[T_BITS-1] ? (T_BITS'(0) - t_x) : t_x;
			mag_y_s4 <= t_y[T_BITS-1] ? (T_BITS'(0) - t_y) : t_y;
			den_s4   <= t_z[T_BITS-1] ? (T_BITS'(0) - t_z) : t_z;

			plo_x_s5 <= (FOCAL_BITS+H)'(focal) * (FOCAL_BITS+H)'(mag_x_s4[H-1:0]);
			plo_y_s5 <= (FOCAL_BITS+H)'(focal) * (FOCAL_BITS+H)'(mag_y_s4[H-1:0]);
			phi_x_s5 <= (FOCAL_BITS+HH)'(focal) * (FOCAL_BITS+HH)'(mag_x_s4[T_BITS-1:H]);
			phi_y_s5 <= (FOCAL_BITS+HH)'(focal) * (FOCAL_BITS+HH)'(mag_y_s4[T_BITS-1:H]);
			den_s5   <= den_s4;

			num_x_s6 <= N_BITS'(plo_x_s5) + (N_BITS'(phi_x_s5) << H);
			num_y_s6 <= N_BITS'(plo_y_s5) + (N_BITS'(phi_y_s5) << H);
			den_s6   <= den_s5;

			rem_x_s7 <= hi_x;
			rem_y_s7 <= hi_y;
			nq_x_s7  <= num_x_s6[QUO_BITS-1:0];
			nq_y_s7  <= num_y_s6[QUO_BITS-1:0];
			den_s7   <= den_s6;
		end
	end

	assign ctl   = ctl_s7;
	assign den   = den_s7;
	assign rem_x = rem_x_s7;
	assign rem_y = rem_y_s7;
	assign nq_x  = nq_x_s7;
	assign nq_y  = nq_y_s7;

endmodule

### hw/rtl/cpp_divide.sv
// Two-lane restoring divider, one quotient bit per pipeline stage.
// Depends on cpp_pkg.
module cpp_divide #(
	parameter int T_BITS = 53
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  cpp_pkg::cpp_ctl_t            ctl_in,
	input  logic [T_BITS-1:0]            den,
	input  logic [T_BITS-1:0]            rem_x,
	input  logic [T_BITS-1:0]            rem_y,
	input  logic [cpp_pkg::QUO_BITS-1:0] nq_x,
	input  logic [cpp_pkg::QUO_BITS-1:0] nq_y,
	output cpp_pkg::cpp_ctl_t            ctl,
	output logic [cpp_pkg::QUO_BITS-1:0] quo_x,
	output logic [cpp_pkg::QUO_BITS-1:0] quo_y
);
	import cpp_pkg::*;

	cpp_ctl_t            ctl_s   [QUO_BITS+1];
	logic [T_BITS-1:0]   den_s   [QUO_BITS+1];
	logic [T_BITS-1:0]   rem_x_s [QUO_BITS+1];
	logic [T_BITS-1:0]   rem_y_s [QUO_BITS+1];
	logic [QUO_BITS-1:0] nq_x_s  [QUO_BITS+1];
	logic [QUO_BITS-1:0] nq_y_s  [QUO_BITS+1];

	assign ctl_s[0]   = ctl_in;
	assign den_s[0]   = den;
	assign rem_x_s[0] = rem_x;
	assign rem_y_s[0] = rem_y;
	assign nq_x_s[0]  = nq_x;
	assign nq_y_s[0]  = nq_y;

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
		logic [T_BITS:0] sh_x, sh_y, dif_x, dif_y;
		logic            ge_x, ge_y;

		// Bring down the next numerator bit, then trial-subtract the divisor.
		assign sh_x  = {rem_x_s[k], nq_x_s[k][QUO_BITS-1]};
		assign sh_y  = {rem_y_s[k], nq_y_s[k][QUO_BITS-1]};
		assign ge_x  = (sh_x >= {1'b0, den_s[k]});
		assign ge_y  = (sh_y >= {1'b0, den_s[k]});
		assign dif_x = sh_x - {1'b0, den_s[k]};
		assign dif_y = sh_y - {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1]   <= den_s[k];
				rem_x_s[k+1] <= ge_x ? dif_x[T_BITS-1:0] : sh_x[T_BITS-1:0];
				rem_y_s[k+1] <= ge_y ? dif_y[T_BITS-1:0] : sh_y[T_BITS-1:0];
				nq_x_s[k+1]  <= {nq_x_s[k][QUO_BITS-2:0], ge_x};
				nq_y_s[k+1]  <= {nq_y_s[k][QUO_BITS-2:0], ge_y};
			end
		end
	end

	assign ctl   = ctl_s[QUO_BITS];
	assign quo_x = nq_x_s[QUO_BITS];
	assign quo_y = nq_y_s[QUO_BITS];

endmodule

### hw/rtl/collinearity_point_projection.sv
// Top level of the collinearity point projection: configuration registers and output stage.
// Depends on cpp_pkg, cpp_rotate, cpp_scale, cpp_divide and the assertion macro header.
//
// Usage. Object points arrive on the input channel (in_valid, in_stall, pt_x, pt_y, pt_z)
// and one projected word leaves on the output channel (out_valid, out_stall, img_x, img_y,
// proj_valid, clipped) for every point taken, in the same order.
// The camera is set through the write port (cfg_we, cfg_idx, cfg_wdata): three rotation
// columns, the projection centre and the focal length. Writes to an unused index are
// ignored. The registers should be written only while no point is in flight.
// An accepted point passes through three stages of translation and rotation, four of
// scaling and divider set-up, 32 divider stages of one quotient bit each, and the output
// register before its result is on the output. One point is taken every cycle while
// the pipeline is not held; the 32-stage divider pipeline sets the latency.
// When the receiver stalls a valid output word, the whole pipeline holds and in_stall is
// raised in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline at once and loads an identity rotation, a centre at the
// origin and a zero focal length.
`include "collinearity_point_projection_defines.svh"

module collinearity_point_projection #(
	parameter int COORD_BITS     = 32,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [COORD_BITS-1:0]          pt_x,
	input  logic signed [COORD_BITS-1:0]          pt_y,
	input  logic signed [COORD_BITS-1:0]          pt_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [cpp_pkg::IMG_BITS-1:0]   img_x,
	output logic signed [cpp_pkg::IMG_BITS-1:0]   img_y,
	output logic                                  proj_valid,
	output logic                                  clipped,
	input  logic                                  cfg_we,
	input  logic [cpp_pkg::CFG_IDX_BITS-1:0]      cfg_idx,
	input  logic [cpp_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
	import cpp_pkg::*;

	localparam int T_BITS = cpp_t_bits(COORD_BITS, COEF_FRAC_BITS);

	typedef struct packed {
		logic                clip;
		logic [IMG_BITS-1:0] val;
	} sat_t;

	logic [ROT_BITS-1:0]          rot_col0_q, rot_col1_q, rot_col2_q;
	logic signed [CAM_BITS-1:0]   cam_x_q, cam_y_q, cam_z_q;
	logic [FOCAL_BITS-1:0]        focal_q;
	logic                         en;
	logic                         t_valid;
	logic [T_BITS-1:0]            t_x, t_y, t_z;
	cpp_ctl_t                     scl_ctl, div_ctl;
	logic [T_BITS-1:0]            den, rem_x, rem_y;
	logic [QUO_BITS-1:0]          nq_x, nq_y, quo_x, quo_y;
	sat_t                         sat_x, sat_y;
	logic                         out_valid_q;
	logic [IMG_BITS-1:0]          img_x_q, img_y_q;
	logic                         proj_valid_q, clipped_q;

	function automatic sat_t saturate(input logic [QUO_BITS-1:0] q, input logic neg,
			input logic ovf);
		sat_t r;
		if (neg) begin
			r.clip = ovf | (q[QUO_BITS-1] & (|q[QUO_BITS-2:0]));
			r.val  = r.clip ? IMG_MAX_NEG : (IMG_BITS'(0) - IMG_BITS'(q));
		end else begin
			r.clip = ovf | q[QUO_BITS-1];
			r.val  = r.clip ? IMG_MAX_POS : IMG_BITS'(q);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_col0_q <= ROT_COL0_RST;
			rot_col1_q <= ROT_COL1_RST;
			rot_col2_q <= ROT_COL2_RST;
			cam_x_q    <= '0;
			cam_y_q    <= '0;
			cam_z_q    <= '0;
			focal_q    <= '0;
		end else if (cfg_we) begin
			case (cpp_reg_t'(cfg_idx))
				REG_ROT_COL0:  rot_col0_q <= cfg_wdata[ROT_BITS-1:0];
				REG_ROT_COL1:  rot_col1_q <= cfg_wdata[ROT_BITS-1:0];
				REG_ROT_COL2:  rot_col2_q <= cfg_wdata[ROT_BITS-1:0];
				REG_CAM_X:     cam_x_q    <= signed'(cfg_wdata[CAM_BITS-1:0]);
				REG_CAM_Y:     cam_y_q    <= signed'(cfg_wdata[CAM_BITS-1:0]);
				REG_CAM_Z:     cam_z_q    <= signed'(cfg_wdata[CAM_BITS-1:0]);
				REG_FOCAL_LEN: focal_q    <= cfg_wdata[FOCAL_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// The pipeline moves as one; it holds only while a finished word is refused.
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	cpp_rotate #(
		.COORD_BITS     (COORD_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.T_BITS         (T_BITS)
	) u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (in_valid),
		.pt_x     (pt_x),
		.pt_y     (pt_y),
		.pt_z     (pt_z),
		.rot_col0 (rot_col0_q),
		.rot_col1 (rot_col1_q),
		.rot_col2 (rot_col2_q),
		.cam_x    (cam_x_q),
		.cam_y    (cam_y_q),
		.cam_z    (cam_z_q),
		.t_valid  (t_valid),
		.t_x      (t_x),
		.t_y      (t_y),
		.t_z      (t_z)
	);

	cpp_scale #(
		.T_BITS (T_BITS)
	) u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.t_valid (t_valid),
		.t_x     (t_x),
		.t_y     (t_y),
		.t_z     (t_z),
		.focal   (focal_q),
		.ctl     (scl_ctl),
		.den     (den),
		.rem_x   (rem_x),
		.rem_y   (rem_y),
		.nq_x    (nq_x),
		.nq_y    (nq_y)
	);

	cpp_divide #(
		.T_BITS (T_BITS)
	) u_divide (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (scl_ctl),
		.den    (den),
		.rem_x  (rem_x),
		.rem_y  (rem_y),
		.nq_x   (nq_x),
		.nq_y   (nq_y),
		.ctl    (div_ctl),
		.quo_x  (quo_x),
		.quo_y  (quo_y)
	);

	assign sat_x = saturate(quo_x, div_ctl.neg_x, div_ctl.ovf_x);
	assign sat_y = saturate(quo_y, div_ctl.neg_y, div_ctl.ovf_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (div_ctl.zero) begin
				img_x_q      <= '0;
				img_y_q      <= '0;
				proj_valid_q <= 1'b0;
				clipped_q    <= 1'b0;
			end else begin
				img_x_q      <= sat_x.val;
				img_y_q      <= sat_y.val;
				proj_valid_q <= 1'b1;
				clipped_q    <= sat_x.clip | sat_y.clip;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign img_x      = signed'(img_x_q);
	assign img_y      = signed'(img_y_q);
	assign proj_valid = proj_valid_q;
	assign clipped    = clipped_q;

	`CPP_ASSERT_IMP(a_invalid_is_zero, out_valid && !proj_valid,
		img_x == '0 && img_y == '0 && !clipped, "invalid projection word is not all zero")
	`CPP_ASSERT_IMP(a_clip_at_limit, out_valid && clipped,
		img_x == signed'(IMG_MAX_POS) || img_x == signed'(IMG_MAX_NEG) ||
		img_y == signed'(IMG_MAX_POS) || img_y == signed'(IMG_MAX_NEG),
		"clipped word has no coordinate at a limit")
	`CPP_ASSERT_IMP(a_zero_focal, out_valid && proj_valid && focal_q == '0,
		img_x == '0 && img_y == '0 && !clipped, "zero focal length gave a nonzero image")
	`CPP_ASSERT_NXT(a_out_drains, out_valid && !out_stall && !div_ctl.valid,
		!out_valid, "output word repeated after it was taken")

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the collinearity point projection: it streams object points under
// several camera settings and checks every projected word against its own exact predictor.
// Depends on cpp_pkg and the collinearity_point_projection RTL.
module tb;
	import cpp_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;
	localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] C_MIN = 32'h8000_0000;
	localparam logic [31:0] C_NEG1 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} point_t;

	typedef struct packed {
		logic [31:0] img_x;
		logic [31:0] img_y;
		logic        proj_valid;
		logic        clipped;
	} image_word_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] pt_x = '0;
	logic signed [31:0] pt_y = '0;
	logic signed [31:0] pt_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [IMG_BITS-1:0] img_x;
	logic signed [IMG_BITS-1:0] img_y;
	logic proj_valid;
	logic clipped;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	logic [ROT_BITS-1:0] rot_cols [3] = '{ROT_COL0_RST, ROT_COL1_RST, ROT_COL2_RST};
	logic [31:0] cam_centre [3] = '{32'd0, 32'd0, 32'd0};
	logic [FOCAL_BITS-1:0] focal_um = '0;

	point_t points_to_send [$];
	image_word_t awaited_images [$];
	point_t next_pt;
	image_word_t want;
	int unsigned tx_wait;
	int unsigned rx_wait;
	int unsigned rx_next;
	int unsigned words_seen;
	int unsigned mismatch_count = 0;
	int unsigned idle_level = 1;
	bit stress_phase = 1'b0;

	collinearity_point_projection u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pt_x       (pt_x),
		.pt_y       (pt_y),
		.pt_z       (pt_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.img_x      (img_x),
		.img_y      (img_y),
		.proj_valid (proj_valid),
		.clipped    (clipped),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] scale_divide(input logic [63:0] num_t, input logic [63:0] den,
			inout logic clip);
		logic [63:0] mag_t;
		logic [63:0] mag_d;
		logic [127:0] quo;
		mag_t = num_t[63] ? 64'd0 - num_t : num_t;
		mag_d = den[63] ? 64'd0 - den : den;
		quo = ({108'd0, focal_um} * {64'd0, mag_t}) / {64'd0, mag_d};
		if (num_t[63] == den[63]) begin
			if (quo > 128'h8000_0000) begin
				clip = 1'b1;
				return IMG_MAX_NEG;
			end
			return 32'd0 - quo[31:0];
		end
		if (quo > 128'h7FFF_FFFF) begin
			clip = 1'b1;
			return IMG_MAX_POS;
		end
		return quo[31:0];
	endfunction

	function automatic image_word_t project_point(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz);
		logic [31:0] pt [3];
		logic [63:0] diff [3];
		logic [63:0] rot [3];
		logic [63:0] coef;
		logic clip;
		image_word_t res;
		int i;
		int k;
		pt[0] = px;
		pt[1] = py;
		pt[2] = pz;
		for (i = 0; i < 3; i++)
			diff[i] = {{32{pt[i][31]}}, pt[i]} - {{32{cam_centre[i][31]}}, cam_centre[i]};
		for (k = 0; k < 3; k++) begin
			rot[k] = '0;
			for (i = 0; i < 3; i++) begin
				coef = {{46{rot_cols[k][18*i+17]}}, rot_cols[k][18*i +: 18]};
				rot[k] = rot[k] + coef * diff[i];
			end
		end
		res = '0;
		if (rot[2] != 64'd0) begin
			clip = 1'b0;
			res.img_x = scale_divide(rot[0], rot[2], clip);
			res.img_y = scale_divide(rot[1], rot[2], clip);
			res.proj_valid = 1'b1;
			res.clipped = clip;
		end
		return res;
	endfunction

	function automatic int unsigned draw_wait();
		if (idle_level == 0)
			return 0;
		if (idle_level == 1)
			return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic logic [31:0] rand_coord(input logic [31:0] centre);
		case ($urandom_range(0, 7))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: return C_MAX;
					1: return C_MIN;
					2: return 32'd0;
					default: return C_NEG1;
				endcase
			end
			3: return centre;
			default: return centre + 32'($urandom_range(0, 20000)) - 32'd10000;
		endcase
	endfunction

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ROT_COL0: rot_cols[0] = data;
			REG_ROT_COL1: rot_cols[1] = data;
			REG_ROT_COL2: rot_cols[2] = data;
			REG_CAM_X: cam_centre[0] = data[31:0];
			REG_CAM_Y: cam_centre[1] = data[31:0];
			REG_CAM_Z: cam_centre[2] = data[31:0];
			REG_FOCAL_LEN: focal_um = data[FOCAL_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic set_camera(input logic [53:0] c0, input logic [53:0] c1, input logic [53:0] c2,
			input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
			input logic [19:0] f);
		write_reg(REG_ROT_COL0, c0);
		write_reg(REG_ROT_COL1, c1);
		write_reg(REG_ROT_COL2, c2);
		write_reg(REG_CAM_X, {22'($urandom), cx});
		write_reg(REG_CAM_Y, {22'($urandom), cy});
		write_reg(REG_CAM_Z, {22'($urandom), cz});
		write_reg(REG_FOCAL_LEN, {34'($urandom), f});
		@(negedge clk);
	endtask

	task automatic queue_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		points_to_send.push_back('{x: x, y: y, z: z});
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (points_to_send.size() != 0 || in_valid || awaited_images.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_phase(input int unsigned count, input bit near_identity);
		logic [17:0] c [3][3];
		logic [31:0] cam_v [3];
		logic [19:0] f;
		int unsigned k;
		int unsigned i;
		int unsigned n;
		for (k = 0; k < 3; k++) begin
			for (i = 0; i < 3; i++) begin
				if (!near_identity)
					c[k][i] = 18'($urandom);
				else if (k == i)
					c[k][i] = 18'(65536 + $urandom_range(0, 2000) - 1000);
				else if (k == 2)
					c[k][i] = 18'd0;
				else
					c[k][i] = 18'($urandom_range(0, 4000) - 2000);
			end
			cam_v[k] = $urandom_range(0, 1) ? $urandom
				: 32'($urandom_range(0, 200000)) - 32'd100000;
		end
		case ($urandom_range(0, 5))
			0: f = 20'd0;
			1: f = 20'hFFFFF;
			default: f = 20'($urandom);
		endcase
		set_camera({c[0][2], c[0][1], c[0][0]}, {c[1][2], c[1][1], c[1][0]},
			{c[2][2], c[2][1], c[2][0]}, cam_v[0], cam_v[1], cam_v[2], f);
		for (n = 0; n < count; n++)
			queue_point(rand_coord(cam_centre[0]), rand_coord(cam_centre[1]),
				rand_coord(cam_centre[2]));
		wait_idle();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pt_x <= '0;
			pt_y <= '0;
			pt_z <= '0;
			tx_wait <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				awaited_images.push_back(project_point(pt_x, pt_y, pt_z));
			if (tx_wait != 0) begin
				in_valid <= 1'b0;
				tx_wait <= tx_wait - 1;
			end else if (points_to_send.size() != 0) begin
				next_pt = points_to_send.pop_front();
				pt_x <= next_pt.x;
				pt_y <= next_pt.y;
				pt_z <= next_pt.z;
				in_valid <= 1'b1;
				tx_wait <= draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait <= 0;
			words_seen <= 0;
		end else begin
			rx_next = rx_wait;
			if (out_valid && !out_stall) begin
				if (awaited_images.size() == 0) begin
					flag_mismatch("output word with no point outstanding");
				end else begin
					want = awaited_images.pop_front();
					if (img_x !== want.img_x)
						flag_mismatch($sformatf("img_x is %0d, expected %0d", img_x,
							$signed(want.img_x)));
					if (img_y !== want.img_y)
						flag_mismatch($sformatf("img_y is %0d, expected %0d", img_y,
							$signed(want.img_y)));
					if (proj_valid !== want.proj_valid)
						flag_mismatch($sformatf("proj_valid is %b, expected %b", proj_valid,
							want.proj_valid));
					if (clipped !== want.clipped)
						flag_mismatch($sformatf("clipped is %b, expected %b", clipped,
							want.clipped));
				end
				words_seen <= words_seen + 1;
				// In a stress phase the receiver now and then holds off long enough to fill the pipeline.
				rx_next = (stress_phase && (words_seen % 97 == 40)) ? 160 : draw_wait();
			end
			if (rx_next != 0) begin
				out_stall <= 1'b1;
				rx_wait <= rx_next - 1;
			end else begin
				out_stall <= 1'b0;
				rx_wait <= 0;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("collinearity_point_projection test failed");
		$finish;
	end

	initial begin
		int unsigned p;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_point(32'd0, 32'd0, 32'd0);
		queue_point(32'd5, 32'hFFFF_FFF9, 32'd100);
		queue_point(C_MAX, C_MIN, C_NEG1);
		wait_idle();

		write_reg(REG_UNMAPPED, {CFG_DATA_BITS{1'b1}});
		set_camera(ROT_COL0_RST, ROT_COL1_RST, ROT_COL2_RST, 32'd0, 32'd0, 32'd0, 20'hFFFFF);
		queue_point(32'd1000, 32'hFFFF_F830, 32'd500);
		queue_point(C_MAX, C_MIN, 32'd1);
		queue_point(C_MIN, C_MAX, C_NEG1);
		queue_point(32'd3, 32'd4, 32'd0);
		queue_point(32'd0, 32'd0, 32'hFFFF_FFFB);
		queue_point(C_NEG1, 32'd1, C_MIN);
		queue_point(32'd123456, 32'hFFF6_0DEF, C_MAX);
		wait_idle();

		set_camera({18'h1FFFF, 18'h20000, 18'h1FFFF}, {18'h20000, 18'h1FFFF, 18'h20000},
			{18'h20000, 18'h1FFFF, 18'h1FFFF}, C_MIN, C_MAX, C_MIN, 20'd1);
		queue_point(C_MAX, C_MIN, C_MAX);
		queue_point(C_MIN, C_MAX, C_MIN);
		queue_point(32'd0, 32'd0, 32'd0);
		queue_point(C_NEG1, 32'd1, C_NEG1);
		wait_idle();

		set_camera(54'd0, 54'd0, {54{1'b1}}, 32'd0, 32'd0, 32'd0, 20'h80000);
		write_reg(REG_UNMAPPED, 54'd0);
		@(negedge clk);
		queue_point(32'd1, 32'd1, 32'hFFFF_FFFE);
		queue_point(32'd1, 32'd2, 32'd3);
		queue_point(C_MAX, C_MAX, C_MAX);
		queue_point(C_MIN, C_MIN, C_MIN);
		wait_idle();

		for (p = 0; p < 10; p++) begin
			stress_phase = (p == 3 || p == 7);
			idle_level = stress_phase ? 0 : p % 3;
			random_phase(130, p[0]);
		end
		stress_phase = 1'b0;

		repeat (45) @(posedge clk);
		if (mismatch_count == 0 && awaited_images.size() == 0)
			$display("collinearity_point_projection test passed");
		else
			$display("collinearity_point_projection test failed");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/cpp_pkg.sv
hw/rtl/cpp_rotate.sv
hw/rtl/cpp_scale.sv
hw/rtl/cpp_divide.sv
hw/rtl/collinearity_point_projection.sv
bench/tb.sv
